// ----- rtl/btmx_pkg.sv -----
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared constants, codes and types of the binary trie maximum-xor block.
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int KEY_BITS   = 31;
	localparam int MAX_ITEMS  = 1024;
	localparam int NODE_DEPTH = 32768;

	// input action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	// no operation: answered with ok and zero
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		OP_INS,
		OP_DEL,
		OP_QRY,
		OP_NOP
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_UPD,
		S_DEL_CHK,
		S_DEL_LEAF,
		S_DEL_UPD,
		S_QRY_ROOT,
		S_QRY_OPP,
		S_QRY_SAME,
		S_DONE
	} eng_state_t;

	function automatic op_t decode_action(logic [1:0] act);
		op_t op;
		case (act)
			ACT_INSERT: op = OP_INS;
			ACT_DELETE: op = OP_DEL;
			ACT_QUERY:  op = OP_QRY;
			default:    op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

// ----- rtl/btmx_front.sv -----
// ----------------------------------------------------------------------------
// btmx_front
// Accepts request transactions, decodes the action and holds them in a
// two-entry queue for the trie engine.
// ----------------------------------------------------------------------------
module btmx_front #(
	parameter int KeyBits = btmx_pkg::KEY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           action,
	input  logic [KeyBits-1:0]   key_value,
	output logic                 cmd_valid,
	output btmx_pkg::op_t        cmd_op,
	output logic [KeyBits-1:0]   cmd_key,
	input  logic                 cmd_pop
);

	btmx_pkg::op_t      op_q  [2];
	logic [KeyBits-1:0] key_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         fill_q;
	logic               push;
	logic               pop;

	assign req_ready = (fill_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd_op    = op_q[rd_ptr_q];
	assign cmd_key   = key_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= btmx_pkg::decode_action(action);
			key_q[wr_ptr_q] <= key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- rtl/btmx_engine.sv -----
// ----------------------------------------------------------------------------
// btmx_engine
// Walks the node memory for insert, delete and query commands and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module btmx_engine #(
	parameter int KeyBits   = btmx_pkg::KEY_BITS,
	parameter int MaxItems  = btmx_pkg::MAX_ITEMS,
	parameter int NodeDepth = btmx_pkg::NODE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  btmx_pkg::op_t        cmd_op,
	input  logic [KeyBits-1:0]   cmd_key,
	output logic                 cmd_pop,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [KeyBits-1:0]   max_xor,
	output logic [1:0]           status
);

	localparam int NODE_W = $clog2(NodeDepth);
	localparam int CNT_W  = $clog2(MaxItems + 1);
	localparam int FREE_W = $clog2(NodeDepth + 1);
	localparam int NEED_W = FREE_W + 1;
	localparam int LVL_W  = (KeyBits > 1) ? $clog2(KeyBits) : 1;
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KeyBits - 1);

	// node memory: pass count and two child links per node
	logic [CNT_W-1:0]  cnt_mem [NodeDepth];
	logic [NODE_W-1:0] c0_mem  [NodeDepth];
	logic [NODE_W-1:0] c1_mem  [NodeDepth];

	btmx_pkg::eng_state_t state_q, state_d;

	logic [KeyBits-1:0] key_q;
	logic [LVL_W-1:0]   lvl_q, lvl_d;
	logic [NODE_W-1:0]  cur_q, cur_d;
	logic [NODE_W-1:0]  same_q, same_d;
	logic [NODE_W-1:0]  opp_q, opp_d;
	logic [KeyBits-1:0] acc_q, acc_d;
	logic [1:0]         st_q, st_d;
	logic [FREE_W-1:0]  free_q, free_d;
	logic               leaf_q, leaf_d;
	logic               first_q, first_d;
	logic               fresh_q, fresh_d;
	logic               root_w_q;
	logic               rd_ok_q;

	logic [NODE_W-1:0]  rd_addr;
	logic [CNT_W-1:0]   rd_cnt;
	logic [NODE_W-1:0]  rd_c0, rd_c1;
	logic               cnt_we, ch_we;
	logic [CNT_W-1:0]   cnt_wd;
	logic [NODE_W-1:0]  c0_wd, c1_wd;
	logic               res_load;

	logic [CNT_W-1:0]   d_cnt;
	logic [NODE_W-1:0]  d_c0, d_c1;
	logic               bit_cur, bit_nxt;
	logic [NODE_W-1:0]  ch_sel, ch_opp, nx_sel, nx_opp, new_ch;
	logic               last, full, room_ok, take;
	logic [NEED_W-1:0]  need;

	// entries never written (root before first insert, fresh nodes) read as zero
	assign d_cnt   = rd_ok_q ? rd_cnt : '0;
	assign d_c0    = rd_ok_q ? rd_c0 : '0;
	assign d_c1    = rd_ok_q ? rd_c1 : '0;
	assign bit_cur = key_q[lvl_q];
	assign bit_nxt = key_q[lvl_q - 1'b1];
	assign ch_sel  = bit_cur ? d_c1 : d_c0;
	assign ch_opp  = bit_cur ? d_c0 : d_c1;
	assign nx_sel  = bit_nxt ? d_c1 : d_c0;
	assign nx_opp  = bit_nxt ? d_c0 : d_c1;
	assign new_ch  = (ch_sel == '0) ? free_q[NODE_W-1:0] : ch_sel;
	assign last    = (lvl_q == '0);
	assign full    = first_q && (d_cnt >= CNT_W'(MaxItems));
	assign need    = NEED_W'(free_q) + NEED_W'(lvl_q) + NEED_W'(1);
	assign room_ok = (need <= NEED_W'(NodeDepth));
	assign take    = (opp_q != '0) && (d_cnt != '0);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cur_q] <= cnt_wd;
		end
		if (ch_we) begin
			c0_mem[cur_q] <= c0_wd;
			c1_mem[cur_q] <= c1_wd;
		end
		rd_cnt <= cnt_mem[rd_addr];
		rd_c0  <= c0_mem[rd_addr];
		rd_c1  <= c1_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			btmx_pkg::S_IDLE: begin
				if (cmd_valid) begin
					case (cmd_op)
						btmx_pkg::OP_INS: state_d = btmx_pkg::S_INS_CHK;
						btmx_pkg::OP_DEL: state_d = btmx_pkg::S_DEL_CHK;
						btmx_pkg::OP_QRY: state_d = btmx_pkg::S_QRY_ROOT;
						default:          state_d = btmx_pkg::S_DONE;
					endcase
				end
			end
			btmx_pkg::S_INS_CHK: begin
				if (full) begin
					state_d = btmx_pkg::S_DONE;
				end else if (ch_sel == '0) begin
					state_d = room_ok ? btmx_pkg::S_INS_UPD : btmx_pkg::S_DONE;
				end else if (last) begin
					state_d = btmx_pkg::S_INS_UPD;
				end
			end
			btmx_pkg::S_INS_UPD: begin
				if (leaf_q) begin
					state_d = btmx_pkg::S_DONE;
				end
			end
			btmx_pkg::S_DEL_CHK: begin
				if (ch_sel == '0) begin
					state_d = btmx_pkg::S_DONE;
				end else if (last) begin
					state_d = btmx_pkg::S_DEL_LEAF;
				end
			end
			btmx_pkg::S_DEL_LEAF: begin
				state_d = (d_cnt == '0) ? btmx_pkg::S_DONE : btmx_pkg::S_DEL_UPD;
			end
			btmx_pkg::S_DEL_UPD: begin
				if (leaf_q) begin
					state_d = btmx_pkg::S_DONE;
				end
			end
			btmx_pkg::S_QRY_ROOT: begin
				state_d = (d_cnt == '0) ? btmx_pkg::S_DONE : btmx_pkg::S_QRY_OPP;
			end
			btmx_pkg::S_QRY_OPP: begin
				if (last) begin
					state_d = btmx_pkg::S_DONE;
				end else if (!take) begin
					state_d = btmx_pkg::S_QRY_SAME;
				end
			end
			btmx_pkg::S_QRY_SAME: begin
				state_d = btmx_pkg::S_QRY_OPP;
			end
			btmx_pkg::S_DONE: begin
				if (!rsp_valid || rsp_ready) begin
					state_d = btmx_pkg::S_IDLE;
				end
			end
			default: state_d = btmx_pkg::S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		rd_addr  = '0;
		cnt_we   = 1'b0;
		ch_we    = 1'b0;
		cnt_wd   = d_cnt;
		c0_wd    = d_c0;
		c1_wd    = d_c1;
		cmd_pop  = 1'b0;
		res_load = 1'b0;
		lvl_d    = lvl_q;
		cur_d    = cur_q;
		same_d   = same_q;
		opp_d    = opp_q;
		acc_d    = acc_q;
		st_d     = st_q;
		free_d   = free_q;
		leaf_d   = leaf_q;
		first_d  = 1'b0;
		fresh_d  = fresh_q;
		case (state_q)
			btmx_pkg::S_IDLE: begin
				cmd_pop = cmd_valid;
				lvl_d   = LVL_TOP;
				cur_d   = '0;
				leaf_d  = 1'b0;
				first_d = 1'b1;
				fresh_d = 1'b0;
				acc_d   = '0;
				st_d    = btmx_pkg::ST_OK;
			end
			btmx_pkg::S_INS_CHK: begin
				if (full) begin
					st_d = btmx_pkg::ST_FULL;
				end else if (ch_sel == '0 || last) begin
					// restart from the root for the update walk
					if (ch_sel == '0 && !room_ok) begin
						st_d = btmx_pkg::ST_FULL;
					end
					lvl_d = LVL_TOP;
				end else begin
					rd_addr = ch_sel;
					lvl_d   = lvl_q - 1'b1;
				end
			end
			btmx_pkg::S_INS_UPD: begin
				cnt_we = 1'b1;
				ch_we  = 1'b1;
				cnt_wd = d_cnt + 1'b1;
				if (!leaf_q) begin
					if (ch_sel == '0) begin
						free_d  = free_q + 1'b1;
						fresh_d = 1'b1;
					end
					if (bit_cur) begin
						c1_wd = new_ch;
					end else begin
						c0_wd = new_ch;
					end
					rd_addr = new_ch;
					cur_d   = new_ch;
					if (last) begin
						leaf_d = 1'b1;
					end else begin
						lvl_d = lvl_q - 1'b1;
					end
				end
			end
			btmx_pkg::S_DEL_CHK: begin
				if (ch_sel == '0) begin
					st_d = btmx_pkg::ST_ABSENT;
				end else begin
					rd_addr = ch_sel;
					if (!last) begin
						lvl_d = lvl_q - 1'b1;
					end
				end
			end
			btmx_pkg::S_DEL_LEAF: begin
				if (d_cnt == '0) begin
					st_d = btmx_pkg::ST_ABSENT;
				end
				lvl_d = LVL_TOP;
			end
			btmx_pkg::S_DEL_UPD: begin
				cnt_we = 1'b1;
				cnt_wd = (d_cnt != '0) ? d_cnt - 1'b1 : d_cnt;
				if (!leaf_q) begin
					rd_addr = ch_sel;
					cur_d   = ch_sel;
					if (last) begin
						leaf_d = 1'b1;
					end else begin
						lvl_d = lvl_q - 1'b1;
					end
				end
			end
			btmx_pkg::S_QRY_ROOT: begin
				if (d_cnt == '0) begin
					st_d = btmx_pkg::ST_EMPTY;
				end else begin
					same_d  = ch_sel;
					opp_d   = ch_opp;
					rd_addr = ch_opp;
				end
			end
			btmx_pkg::S_QRY_OPP: begin
				// the opposite candidate's entry is on the read port
				acc_d = (acc_q << 1) | KeyBits'(take);
				if (!last) begin
					lvl_d = lvl_q - 1'b1;
					if (take) begin
						same_d  = nx_sel;
						opp_d   = nx_opp;
						rd_addr = nx_opp;
					end else begin
						rd_addr = same_q;
					end
				end
			end
			btmx_pkg::S_QRY_SAME: begin
				same_d  = ch_sel;
				opp_d   = ch_opp;
				rd_addr = ch_opp;
			end
			btmx_pkg::S_DONE: begin
				res_load = !rsp_valid || rsp_ready;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q   <= (state_q == btmx_pkg::S_IDLE) ? cmd_key : key_q;
		lvl_q   <= lvl_d;
		cur_q   <= cur_d;
		same_q  <= same_d;
		opp_q   <= opp_d;
		acc_q   <= acc_d;
		st_q    <= st_d;
		leaf_q  <= leaf_d;
		first_q <= first_d;
		rd_ok_q <= ((rd_addr != '0) || root_w_q) && !fresh_d;
		if (res_load) begin
			max_xor <= acc_q;
			status  <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= btmx_pkg::S_IDLE;
			free_q    <= FREE_W'(1);
			fresh_q   <= 1'b0;
			root_w_q  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			if (ch_we && cur_q == '0) begin
				root_w_q <= 1'b1;
			end
			if (res_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/binary_trie_max_xor.sv -----
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie over KeyBits-bit keys: insert, delete and maximum-xor query.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready, action, key_value) carries one
// command per transaction: insert, delete, or query the largest xor of
// key_value with any stored key. Response channel (rsp_valid/rsp_ready,
// max_xor, status) returns exactly one transaction per request, in order.
// A two-entry queue sits between the request port and the trie engine, and
// the response sits in its own register, so requests keep being taken while
// a response waits; a stalled receiver stops the engine only once it has
// a second result ready.
// Each command walks the node memory one node a step:
//   insert  check walk, then update walk
//   delete  check walk, leaf check, then update walk
//   query   a step whose opposite branch is empty costs one extra read
//   invalid action  goes straight to the done state
// Reset empties the trie at once: no clearing pass is needed, untouched
// node entries read as empty.
// ----------------------------------------------------------------------------
module binary_trie_max_xor #(
	parameter int KeyBits   = btmx_pkg::KEY_BITS,
	parameter int MaxItems  = btmx_pkg::MAX_ITEMS,
	parameter int NodeDepth = btmx_pkg::NODE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           action,
	input  logic [KeyBits-1:0]   key_value,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [KeyBits-1:0]   max_xor,
	output logic [1:0]           status
);

	logic               cmd_valid;
	btmx_pkg::op_t      cmd_op;
	logic [KeyBits-1:0] cmd_key;
	logic               cmd_pop;

	btmx_front #(
		.KeyBits (KeyBits)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.key_value (key_value),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd_op),
		.cmd_key   (cmd_key),
		.cmd_pop   (cmd_pop)
	);

	btmx_engine #(
		.KeyBits   (KeyBits),
		.MaxItems  (MaxItems),
		.NodeDepth (NodeDepth)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd_op),
		.cmd_key   (cmd_key),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.max_xor   (max_xor),
		.status    (status)
	);

endmodule
